>>> rtl/gpx_pkg.sv
// Shared types, register addresses and constants of the GPIO expander register block.
`timescale 1ns / 1ps
`default_nettype none

package gpx_pkg;

    // Register file geometry
    localparam int REG_COUNT = 22;
    localparam int PTR_W     = 8;
    localparam int IDX_W     = $clog2(REG_COUNT);

    // Register addresses (port A / port B)
    localparam logic [PTR_W-1:0] ADDR_DIR_A  = 8'h00;
    localparam logic [PTR_W-1:0] ADDR_DIR_B  = 8'h01;
    localparam logic [PTR_W-1:0] ADDR_PU_A   = 8'h0C;
    localparam logic [PTR_W-1:0] ADDR_PU_B   = 8'h0D;
    localparam logic [PTR_W-1:0] ADDR_GPIO_A = 8'h12;
    localparam logic [PTR_W-1:0] ADDR_GPIO_B = 8'h13;
    localparam logic [PTR_W-1:0] ADDR_LAT_A  = 8'h14;
    localparam logic [PTR_W-1:0] ADDR_LAT_B  = 8'h15;

    localparam logic [7:0] DIR_RESET = 8'hFF;
    localparam logic [7:0] READ_MISS = 8'hFF;

    // Pointer wrap: (p + 1) mod REG_COUNT by reciprocal multiply, exact for p + 1 <= 256
    localparam int SUM_W      = PTR_W + 1;
    localparam int ADV_SHIFT  = 14;
    localparam int ADV_RECIP  = (1 << ADV_SHIFT) / REG_COUNT + 1;
    localparam int RECIP_W    = $clog2(ADV_RECIP + 1);
    localparam int PROD_W     = SUM_W + RECIP_W;
    localparam int QUOT_W     = $clog2((1 << PTR_W) / REG_COUNT + 1);

    // Bus event codes
    typedef enum logic [1:0] {
        MODE_WR_START = 2'd0,
        MODE_RD_START = 2'd1,
        MODE_RD_BYTE  = 2'd2,
        MODE_WR_BYTE  = 2'd3
    } mode_t;

    // One bus event
    typedef struct packed {
        mode_t      mode;
        logic [7:0] data_byte;
        logic [15:0] pin_levels;
    } req_t;

    // One result item
    typedef struct packed {
        logic [15:0] pullup_enable;
        logic [15:0] drive_level;
        logic [15:0] drive_enable;
        logic [7:0]  read_data;
    } res_t;

endpackage

`default_nettype wire

>>> rtl/gpx_regfile.sv
// Register file, register pointer and bus event decode of the GPIO expander.
`timescale 1ns / 1ps
`default_nettype none

module gpx_regfile (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    input  wire gpx_pkg::req_t req,
    output gpx_pkg::res_t      res
);

    logic [7:0]                 rf_reg  [gpx_pkg::REG_COUNT];
    logic [7:0]                 rf_next [gpx_pkg::REG_COUNT];
    logic [gpx_pkg::PTR_W-1:0]  ptr_reg;
    logic [gpx_pkg::PTR_W-1:0]  ptr_next;
    logic                       loaded_reg;
    logic                       loaded_next;

    logic                       ptr_in_range;
    logic [gpx_pkg::IDX_W-1:0]  ptr_idx;
    logic [gpx_pkg::SUM_W-1:0]  ptr_sum;
    logic [gpx_pkg::PROD_W-1:0] ptr_prod;
    logic [gpx_pkg::QUOT_W-1:0] ptr_quot;
    logic [gpx_pkg::PTR_W-1:0]  ptr_adv;
    logic [7:0]                 rd_byte;
    logic [7:0]                 dir_a;
    logic [7:0]                 dir_b;
    logic [7:0]                 lat_a;
    logic [7:0]                 lat_b;

    assign ptr_in_range = ({1'b0, ptr_reg} < gpx_pkg::SUM_W'(gpx_pkg::REG_COUNT));
    assign ptr_idx      = ptr_reg[gpx_pkg::IDX_W-1:0];

    // Pointer advance: quotient by reciprocal multiply, remainder by one subtract
    assign ptr_sum  = {1'b0, ptr_reg} + gpx_pkg::SUM_W'(1);
    assign ptr_prod = gpx_pkg::PROD_W'(ptr_sum) * gpx_pkg::PROD_W'(gpx_pkg::ADV_RECIP);
    assign ptr_quot = ptr_prod[gpx_pkg::ADV_SHIFT +: gpx_pkg::QUOT_W];
    assign ptr_adv  = gpx_pkg::PTR_W'(ptr_sum
                      - gpx_pkg::SUM_W'(ptr_quot) * gpx_pkg::SUM_W'(gpx_pkg::REG_COUNT));

    assign dir_a = rf_reg[gpx_pkg::ADDR_DIR_A[gpx_pkg::IDX_W-1:0]];
    assign dir_b = rf_reg[gpx_pkg::ADDR_DIR_B[gpx_pkg::IDX_W-1:0]];
    assign lat_a = rf_reg[gpx_pkg::ADDR_LAT_A[gpx_pkg::IDX_W-1:0]];
    assign lat_b = rf_reg[gpx_pkg::ADDR_LAT_B[gpx_pkg::IDX_W-1:0]];

    // Event decode and next state
    always_comb
    begin
        rf_next     = rf_reg;
        ptr_next    = ptr_reg;
        loaded_next = loaded_reg;
        rd_byte     = '0;
        unique case (req.mode)
            gpx_pkg::MODE_WR_START:
            begin
                loaded_next = 1'b0;
            end
            gpx_pkg::MODE_RD_START:
            begin
                // snapshot: inputs show the pin, outputs show their latch
                rf_next[gpx_pkg::ADDR_GPIO_A[gpx_pkg::IDX_W-1:0]] =
                    (dir_a & req.pin_levels[7:0]) | (~dir_a & lat_a);
                rf_next[gpx_pkg::ADDR_GPIO_B[gpx_pkg::IDX_W-1:0]] =
                    (dir_b & req.pin_levels[15:8]) | (~dir_b & lat_b);
            end
            gpx_pkg::MODE_RD_BYTE:
            begin
                rd_byte  = ptr_in_range ? rf_reg[ptr_idx] : gpx_pkg::READ_MISS;
                ptr_next = ptr_adv;
            end
            gpx_pkg::MODE_WR_BYTE:
            begin
                if (!loaded_reg)
                begin
                    ptr_next    = req.data_byte;
                    loaded_next = 1'b1;
                end
                else
                begin
                    if (ptr_in_range)
                    begin
                        rf_next[ptr_idx] = req.data_byte;
                        // GPIO writes also land in the port latch
                        if (ptr_reg == gpx_pkg::ADDR_GPIO_A)
                        begin
                            rf_next[gpx_pkg::ADDR_LAT_A[gpx_pkg::IDX_W-1:0]] = req.data_byte;
                        end
                        else if (ptr_reg == gpx_pkg::ADDR_GPIO_B)
                        begin
                            rf_next[gpx_pkg::ADDR_LAT_B[gpx_pkg::IDX_W-1:0]] = req.data_byte;
                        end
                    end
                    ptr_next = ptr_adv;
                end
            end
            default:
            begin
                loaded_next = loaded_reg;
            end
        endcase
    end

    // Result from the updated register file
    always_comb
    begin
        res.read_data     = rd_byte;
        res.drive_enable  = ~{rf_next[gpx_pkg::ADDR_DIR_B[gpx_pkg::IDX_W-1:0]],
                              rf_next[gpx_pkg::ADDR_DIR_A[gpx_pkg::IDX_W-1:0]]};
        res.drive_level   = {rf_next[gpx_pkg::ADDR_LAT_B[gpx_pkg::IDX_W-1:0]],
                             rf_next[gpx_pkg::ADDR_LAT_A[gpx_pkg::IDX_W-1:0]]};
        res.pullup_enable = {rf_next[gpx_pkg::ADDR_DIR_B[gpx_pkg::IDX_W-1:0]],
                             rf_next[gpx_pkg::ADDR_DIR_A[gpx_pkg::IDX_W-1:0]]}
                          & {rf_next[gpx_pkg::ADDR_PU_B[gpx_pkg::IDX_W-1:0]],
                             rf_next[gpx_pkg::ADDR_PU_A[gpx_pkg::IDX_W-1:0]]};
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // direction registers come up as all inputs, the rest clear
            for (int i = 0; i < gpx_pkg::REG_COUNT; i++)
            begin
                if ((i == int'(gpx_pkg::ADDR_DIR_A)) || (i == int'(gpx_pkg::ADDR_DIR_B)))
                begin
                    rf_reg[i] <= gpx_pkg::DIR_RESET;
                end
                else
                begin
                    rf_reg[i] <= '0;
                end
            end
            ptr_reg    <= '0;
            loaded_reg <= 1'b0;
        end
        else if (req_valid)
        begin
            rf_reg     <= rf_next;
            ptr_reg    <= ptr_next;
            loaded_reg <= loaded_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/i2c_gpio_expander_registers.sv
// Top level of the GPIO expander register block: stream ports and result buffer.
//
// Usage: every bus event (write start, read start, read byte, write byte) enters
// as one request on the s_* stream; mode rides in s_tuser, the data byte and the
// 16 live pin levels in s_tdata. Each request produces exactly one result on the
// m_* stream: the read byte (zero unless the request was a read byte) plus the
// pin drive enables, drive levels and pull-up enables after the update.
// Results are registered, in the output register or, if it is held, the skid one.
// Throughput: one request per cycle while s_tready is high; the register file,
// pointer and flag are updated in the accepting cycle, so a request can follow in
// the next cycle. Stall: an output register plus one skid register hold results;
// s_tready drops only while both are full, and results leave in request order.
// Reset: direction registers go to all inputs, all other registers, the pointer
// and the pointer-loaded flag clear; no result is pending.
`timescale 1ns / 1ps
`default_nettype none

module i2c_gpio_expander_registers (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [7:0] data_byte, [23:8] pin_levels
    input  wire logic [1:0]  s_tuser,   // [1:0] mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata    // [7:0] read_data, [23:8] drive_enable,
                                        // [39:24] drive_level, [55:40] pullup_enable
);

    gpx_pkg::req_t req;
    gpx_pkg::res_t res;
    gpx_pkg::res_t out_reg;
    gpx_pkg::res_t skid_reg;
    logic          out_valid_reg;
    logic          skid_valid_reg;
    logic          accept;
    logic          pop;

    assign req.mode       = gpx_pkg::mode_t'(s_tuser);
    assign req.data_byte  = s_tdata[7:0];
    assign req.pin_levels = s_tdata[23:8];

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign pop      = !out_valid_reg || m_tready;

    gpx_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (accept),
        .req       (req),
        .res       (res)
    );

    // Output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept)
        begin
            if (pop)
            begin
                out_reg <= res;
            end
            else
            begin
                skid_reg <= res;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.pullup_enable, out_reg.drive_level,
                       out_reg.drive_enable, out_reg.read_data};

endmodule

`default_nettype wire
